// File: design/dhpi_pkg.sv
// Shared types and constants for the double-hash probe index block.
// No dependencies; imported by double_hash_probe_index.
`default_nettype none

package dhpi_pkg;

   localparam int unsigned HASH_W     = 32;
   localparam int unsigned SIZE_W     = 31;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned ATT_W      = 16;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 48;
   localparam int unsigned CNT_W      = 5;
   localparam int unsigned MUL_STEPS  = ATT_W;
   localparam int unsigned DIV_STEPS  = HASH_W;

   localparam logic [HASH_W-1:0] DJB2_SEED  = 32'd5381;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 31'd53;

   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ABSORB = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PROBE  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_MIX1,
      ST_MIX2,
      ST_MUL,
      ST_MAG,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// File: design/double_hash_probe_index.sv
// Double-hash probe index generator: djb2 and one-at-a-time running hashes, bit-serial
// multiply and bit-serial restoring modulo. Depends on dhpi_pkg.
// Clear and ignored items act at accept and a key byte also passes the absorb state; a probe
// runs through 2 mix, 16 multiply, 1 magnitude and 32 modulo steps, then a load.
// One item in work at a time: a probe holds off the input until its result is loaded.
// Synchronous active-high reset: table_size 53, first hash 5381, second hash 0.
`default_nettype none

module double_hash_probe_index
   import dhpi_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // key_byte[7:0], attempt[23:8]
   input  wire logic [MODE_W-1:0]     req_tuser,   // mode[1:0]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // probe_index[30:0], probe_attempt[46:31]
   input  wire logic                  csr_wen,
   input  wire logic [SIZE_W-1:0]     csr_wdata    // table_size[30:0]
);

   state_type state_ff, state_in;

   logic [HASH_W-1:0] h1_ff, h1_in;
   logic [HASH_W-1:0] h2_ff, h2_in;
   logic [HASH_W-1:0] work_ff, work_in;
   logic [HASH_W-1:0] acc_ff, acc_in;
   logic [HASH_W-1:0] rem_ff, rem_in;
   logic [ATT_W-1:0]  att_ff, att_in;
   logic [ATT_W-1:0]  mult_ff, mult_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SIZE_W-1:0] tsize_ff, tsize_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SIZE_W-1:0] rsp_index_ff, rsp_index_in;
   logic [ATT_W-1:0]  rsp_att_ff, rsp_att_in;

   logic              req_fire;
   logic              load_rsp;
   logic [MODE_W-1:0] req_mode;
   logic [BYTE_W-1:0] req_byte;
   logic [ATT_W-1:0]  req_att;
   logic [HASH_W-1:0] byte_ext;
   logic [HASH_W-1:0] oat_sum;
   logic [HASH_W-1:0] trial;
   logic [HASH_W-1:0] trial_diff;
   logic              trial_ge;

   assign req_mode = req_tuser;
   assign req_byte = req_tdata[BYTE_W-1:0];
   assign req_att  = req_tdata[BYTE_W +: ATT_W];
   assign byte_ext = {{(HASH_W-BYTE_W){req_byte[BYTE_W-1]}}, req_byte};
   assign req_fire = req_tvalid && req_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_mode == MODE_ABSORB && req_byte != '0) begin
                  state_in = ST_ABSORB;
               end else if (req_mode == MODE_PROBE) begin
                  state_in = ST_MIX1;
               end
            end
         end
         ST_ABSORB: state_in = ST_IDLE;
         ST_MIX1:   state_in = ST_MIX2;
         ST_MIX2:   state_in = ST_MUL;
         ST_MUL: begin
            if (cnt_ff == CNT_W'(MUL_STEPS-1)) begin
               state_in = ST_MAG;
            end
         end
         ST_MAG: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == CNT_W'(DIV_STEPS-1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      load_rsp   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   end

   // One modulo step: bring in the next dividend bit and subtract if it fits.
   assign trial      = {rem_ff[HASH_W-2:0], acc_ff[HASH_W-1]};
   assign trial_ge   = (trial >= {1'b0, tsize_ff});
   assign trial_diff = trial - {1'b0, tsize_ff};

   assign oat_sum = h2_ff + (h2_ff << 10);

   always_comb begin
      h1_in    = h1_ff;
      h2_in    = h2_ff;
      work_in  = work_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      att_in   = att_ff;
      mult_in  = mult_ff;
      cnt_in   = '0;
      tsize_in = csr_wen ? csr_wdata : tsize_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_mode)
                  MODE_CLEAR: begin
                     h1_in = DJB2_SEED;
                     h2_in = '0;
                  end
                  MODE_ABSORB: begin
                     if (req_byte != '0) begin
                        h1_in = (h1_ff << 5) + h1_ff + byte_ext;
                        h2_in = h2_ff + byte_ext;
                     end
                  end
                  MODE_PROBE: begin
                     att_in  = req_att;
                     mult_in = req_att;
                     work_in = h2_ff + (h2_ff << 3);
                  end
                  default: begin
                     h1_in = h1_ff;
                  end
               endcase
            end
         end
         ST_ABSORB: begin
            h2_in = oat_sum ^ HASH_W'($signed(oat_sum) >>> 6);
         end
         ST_MIX1: begin
            work_in = work_ff ^ HASH_W'($signed(work_ff) >>> 11);
         end
         ST_MIX2: begin
            // The +1 of the probe step folds into the last mix add.
            work_in = work_ff + (work_ff << 15) + HASH_W'(1);
            acc_in  = h1_ff;
         end
         ST_MUL: begin
            if (mult_ff[0]) begin
               acc_in = acc_ff + work_ff;
            end
            work_in = work_ff << 1;
            mult_in = mult_ff >> 1;
            if (cnt_ff != CNT_W'(MUL_STEPS-1)) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_MAG: begin
            // The most negative sum negates to itself, read as 2^31 unsigned.
            if (acc_ff[HASH_W-1]) begin
               acc_in = '0 - acc_ff;
            end
            rem_in = '0;
         end
         ST_DIV: begin
            rem_in = trial_ge ? trial_diff : trial;
            acc_in = acc_ff << 1;
            if (cnt_ff != CNT_W'(DIV_STEPS-1)) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            cnt_in = '0;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_comb begin
      rsp_index_in = rsp_index_ff;
      rsp_att_in   = rsp_att_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = (tsize_ff == '0) ? '0 : rem_ff[SIZE_W-1:0];
         rsp_att_in   = att_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         tsize_ff     <= SIZE_RESET;
         h1_ff        <= DJB2_SEED;
         h2_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         tsize_ff     <= tsize_in;
         h1_ff        <= h1_in;
         h2_ff        <= h2_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      att_ff       <= att_in;
      mult_ff      <= mult_in;
      rsp_index_ff <= rsp_index_in;
      rsp_att_ff   <= rsp_att_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_att_ff, rsp_index_ff};

`ifndef SYNTHESIS
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && tsize_ff != '0 |-> rsp_index_ff < tsize_ff)
      else $error("probe index not below table size");

   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result loaded outside the done state");

   a_idle_count_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> cnt_ff == '0)
      else $error("step counter not cleared in idle");
`endif

endmodule

`default_nettype wire

// File: bench/dhpi_probe_checker.sv
// Checker for double_hash_probe_index: watches the request, result and register ports,
// predicts each probe index from its own copy of the hashes and compares. Uses dhpi_pkg.
module dhpi_probe_checker
   import dhpi_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [MODE_W-1:0]     req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_wen,
   input  wire logic [SIZE_W-1:0]     csr_wdata,
   output int                         fail_count,
   output int                         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [SIZE_W-1:0] index;
      logic [ATT_W-1:0]  attempt;
   } probe_result_type;

   probe_result_type  expected_probes[$];
   logic [SIZE_W-1:0] table_size;
   logic [HASH_W-1:0] djb2_hash;
   logic [HASH_W-1:0] oaat_hash;
   int                mismatches = 0;

   function automatic logic [HASH_W-1:0] shift_right_arith(input logic signed [HASH_W-1:0] x,
                                                         input int n);
      return x >>> n;
   endfunction

   always @(posedge clock) begin
      probe_result_type  want;
      logic [SIZE_W-1:0] got_index;
      logic [ATT_W-1:0]  got_attempt;
      logic [ATT_W-1:0]  attempt;
      logic [HASH_W-1:0] key_char;
      logic [HASH_W-1:0] mixed;
      logic [HASH_W-1:0] total;
      logic [HASH_W-1:0] magnitude;
      logic [HASH_W-1:0] slot;
      if (reset) begin
         table_size = SIZE_RESET;
         djb2_hash  = DJB2_SEED;
         oaat_hash  = '0;
         expected_probes.delete();
      end else begin
         // Results are checked before requests: a result never belongs to an item
         // accepted at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            got_index   = rsp_tdata[SIZE_W-1:0];
            got_attempt = rsp_tdata[SIZE_W +: ATT_W];
            if (expected_probes.size() == 0) begin
               $display("%0t: result with none expected: index %0d attempt %0d",
                        $time, got_index, got_attempt);
               mismatches++;
            end else begin
               want = expected_probes.pop_front();
               if (got_index !== want.index) begin
                  $display("%0t: probe_index expected %0d, actual %0d (attempt %0d)",
                           $time, want.index, got_index, want.attempt);
                  mismatches++;
               end
               if (got_attempt !== want.attempt) begin
                  $display("%0t: probe_attempt expected %0d, actual %0d",
                           $time, want.attempt, got_attempt);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               MODE_CLEAR: begin
                  djb2_hash = DJB2_SEED;
                  oaat_hash = '0;
               end
               MODE_ABSORB: begin
                  // A zero byte terminates a key and leaves both hashes alone.
                  if (req_tdata[BYTE_W-1:0] != '0) begin
                     key_char  = {{(HASH_W-BYTE_W){req_tdata[BYTE_W-1]}},
                                  req_tdata[BYTE_W-1:0]};
                     djb2_hash = (djb2_hash << 5) + djb2_hash + key_char;
                     oaat_hash = oaat_hash + key_char;
                     oaat_hash = oaat_hash + (oaat_hash << 10);
                     oaat_hash = oaat_hash ^ shift_right_arith(oaat_hash, 6);
                  end
               end
               MODE_PROBE: begin
                  attempt   = req_tdata[BYTE_W +: ATT_W];
                  mixed     = oaat_hash + (oaat_hash << 3);
                  mixed     = mixed ^ shift_right_arith(mixed, 11);
                  mixed     = mixed + (mixed << 15);
                  total     = djb2_hash + HASH_W'(attempt) * (mixed + 32'd1);
                  // The most negative sum keeps its bit pattern, read as 2^31 unsigned.
                  magnitude = total[HASH_W-1] ? (32'd0 - total) : total;
                  slot      = (table_size == '0) ? '0 : magnitude % {1'b0, table_size};
                  want.index   = slot[SIZE_W-1:0];
                  want.attempt = attempt;
                  expected_probes.push_back(want);
               end
               default: ;
            endcase
         end
         if (csr_wen)
            table_size = csr_wdata;
      end
      pending_count <= expected_probes.size();
      fail_count    <= mismatches;
   end

endmodule

// File: bench/tb_double_hash_probe_index.sv
// Testbench top for double_hash_probe_index: clock, reset, key and probe stimulus,
// table size writes and the verdict. Depends on dhpi_pkg, the block and dhpi_probe_checker.
module tb_double_hash_probe_index;
   timeunit 1ns;
   timeprecision 1ps;

   import dhpi_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES    = 60;
   localparam int PHASES           = 10;
   localparam int PHASE_ITEMS      = 75;
   localparam int LONG_HOLD_CYCLES = 300;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // key_byte[7:0], attempt[23:8]
   logic [MODE_W-1:0]     req_tuser  = '0;   // mode[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // probe_index[30:0], probe_attempt[46:31]
   logic                  csr_wen    = 1'b0;
   logic [SIZE_W-1:0]     csr_wdata  = '0;   // table_size[30:0]
   int                    fail_count;
   int                    pending_count;
   bit                    gaps_on       = 1'b0;
   bit                    stalls_on     = 1'b0;
   bit                    long_hold_req = 1'b0;

   double_hash_probe_index u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   dhpi_probe_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // Result side: short random stalls, and one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Leaves tvalid high after the accept so back-to-back items need no second assignment.
   task automatic offer_item(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] key_byte,
                             input logic [ATT_W-1:0] attempt);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {attempt, key_byte};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      // A key byte may still be in work after the last result.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_table_size(input logic [SIZE_W-1:0] value);
      wait_all_results();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   initial begin
      logic [BYTE_W-1:0] min_key[$];
      logic [BYTE_W-1:0] digits[$];
      longint unsigned   seed_term;
      longint            remainder;
      longint            digit;
      logic [SIZE_W-1:0] next_size;
      logic [MODE_W-1:0] mode;
      logic [BYTE_W-1:0] key_byte;
      logic [ATT_W-1:0]  attempt;
      int                phase_items;

      // Build a key whose djb2 hash lands on 0x80000000, so that a probe with attempt 0
      // sums to the most negative value. The bytes are signed base-33 digits of the
      // distance from the seed term; a zero digit is replaced by 33.
      for (int n = 7; n < 16 && min_key.size() == 0; n++) begin
         seed_term = 64'd5381;
         repeat (n) seed_term = (seed_term * 33) % 64'h1_0000_0000;
         for (int k = -2; k <= 2 && min_key.size() == 0; k++) begin
            remainder = 64'sh8000_0000 - longint'(seed_term) + longint'(k) * 64'sh1_0000_0000;
            digits.delete();
            repeat (n) begin
               digit = remainder % 33;
               if (digit > 16)
                  digit -= 33;
               else if (digit < -16)
                  digit += 33;
               if (digit == 0)
                  digit = 33;
               remainder = (remainder - digit) / 33;
               digits.push_front(digit[7:0]);
            end
            if (remainder == 0)
               min_key = digits;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      gaps_on   = 1'b1;
      stalls_on = 1'b1;

      offer_item(MODE_PROBE, 8'h00, 16'h0000);
      offer_item(MODE_ABSORB, 8'h00, 16'hFFFF);
      offer_item(MODE_ABSORB, 8'h80, 16'h0000);
      offer_item(MODE_ABSORB, 8'h7F, 16'h0000);
      offer_item(MODE_UNUSED, 8'hFF, 16'hFFFF);
      offer_item(MODE_ABSORB, 8'hFF, 16'h0000);
      offer_item(MODE_ABSORB, 8'h55, 16'hAAAA);
      offer_item(MODE_PROBE, 8'hFF, 16'hFFFF);
      offer_item(MODE_PROBE, 8'hAA, 16'h5555);
      offer_item(MODE_CLEAR, 8'hFF, 16'hFFFF);
      foreach (min_key[i])
         offer_item(MODE_ABSORB, min_key[i], 16'h0000);
      offer_item(MODE_PROBE, 8'h00, 16'h0000);
      // The hashes survive a register write, so the same key is probed at other sizes.
      set_table_size(31'h7FFF_FFFF);
      offer_item(MODE_PROBE, 8'h00, 16'h0000);
      set_table_size('0);
      offer_item(MODE_PROBE, 8'h00, 16'hFFFF);
      set_table_size(31'd1);
      offer_item(MODE_PROBE, 8'h00, 16'h8001);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: next_size = SIZE_RESET;
            1: next_size = 31'd1;
            2: next_size = 31'h7FFF_FFFF;
            3: next_size = 31'd2;
            4: next_size = '0;
            5: next_size = SIZE_W'($urandom_range(3, 1000));
            6: next_size = SIZE_W'($urandom);
            7: next_size = 31'h4000_0000;
            8: next_size = 31'd97;
            default: next_size = SIZE_W'($urandom_range(1, 60000));
         endcase
         set_table_size(next_size);
         gaps_on   = (phase < PHASES - 2) && ($urandom_range(0, 4) != 0);
         stalls_on = (phase < PHASES - 2) && ($urandom_range(0, 4) != 0);
         if (phase == 3)
            long_hold_req = 1'b1;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 6) != 0) begin
               // A well-formed key: clear, some bytes, then a few probe attempts.
               offer_item(MODE_CLEAR, BYTE_W'($urandom), ATT_W'($urandom));
               phase_items++;
               repeat ($urandom_range(0, 12)) begin
                  key_byte = ($urandom_range(0, 9) == 0) ? 8'h00
                                                         : BYTE_W'($urandom_range(1, 255));
                  offer_item(MODE_ABSORB, key_byte, ATT_W'($urandom));
                  if (key_byte != '0)
                     phase_items++;
               end
               repeat ($urandom_range(1, 4)) begin
                  case ($urandom_range(0, 7))
                     0: attempt = '0;
                     1: attempt = '1;
                     default: attempt = ATT_W'($urandom);
                  endcase
                  offer_item(MODE_PROBE, BYTE_W'($urandom), attempt);
                  phase_items++;
               end
            end else begin
               mode     = MODE_W'($urandom_range(0, 3));
               key_byte = BYTE_W'($urandom);
               offer_item(mode, key_byte, ATT_W'($urandom));
               if (mode == MODE_CLEAR || mode == MODE_PROBE
                   || (mode == MODE_ABSORB && key_byte != '0))
                  phase_items++;
            end
         end
      end

      wait_all_results();
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
